### hw/rtl/ldcf_pkg.sv
// ============================================================================
// ldcf_pkg
// Shared types, codes and constants of the LED driver chain framer.
// ============================================================================
package ldcf_pkg;

    localparam int MAX_CHAIN_DEF = 8;

    typedef enum logic [3:0] {
        CMD_WRITE_DIGIT  = 4'd0,
        CMD_CLEAR_DIGIT  = 4'd1,
        CMD_INIT_DEV     = 4'd2,
        CMD_ENABLE_DEV   = 4'd3,
        CMD_DISABLE_DEV  = 4'd4,
        CMD_DEV_ALL_ON   = 4'd5,
        CMD_DEV_ALL_OFF  = 4'd6,
        CMD_INIT_ALL     = 4'd7,
        CMD_ENABLE_ALL   = 4'd8,
        CMD_DISABLE_ALL  = 4'd9,
        CMD_TEST_ON      = 4'd10,
        CMD_TEST_OFF     = 4'd11
    } cmd_t;

    localparam logic [3:0] REG_NOOP      = 4'h0;
    localparam logic [3:0] REG_DECODE    = 4'h9;
    localparam logic [3:0] REG_INTENSITY = 4'hA;
    localparam logic [3:0] REG_SCANLIM   = 4'hB;
    localparam logic [3:0] REG_SHUTDOWN  = 4'hC;
    localparam logic [3:0] REG_TEST      = 4'hF;

    localparam logic [7:0] DIGIT_LO    = 8'd1;
    localparam logic [7:0] DIGIT_HI    = 8'd8;
    localparam logic [7:0] ALL_ON_BYTE = 8'hFF;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_DEV_BEYOND   = 3'd1;
    localparam logic [2:0] ST_DEV_ZERO     = 3'd2;
    localparam logic [2:0] ST_DIGIT_HIGH   = 3'd3;
    localparam logic [2:0] ST_DIGIT_LOW    = 3'd4;

    localparam logic [3:0] CFG_CHAIN_LENGTH = 4'd0;
    localparam logic [3:0] CFG_DECODE_MODE  = 4'd1;
    localparam logic [3:0] CFG_INTENSITY    = 4'd2;
    localparam logic [3:0] CFG_SCAN_LIMIT   = 4'd3;

    typedef logic [4:0] step_t;

    localparam step_t STEP_FETCH         = 5'd0;
    localparam step_t STEP_STATUS        = 5'd1;
    localparam step_t STEP_WRITE_DIGIT   = 5'd2;
    localparam step_t STEP_CLEAR_DIGIT   = 5'd3;
    localparam step_t STEP_INIT_DEV      = 5'd4;
    localparam step_t STEP_INIT_DEV_INT  = 5'd5;
    localparam step_t STEP_INIT_DEV_SCAN = 5'd6;
    localparam step_t STEP_INIT_ALL      = 5'd7;
    localparam step_t STEP_INIT_ALL_INT  = 5'd8;
    localparam step_t STEP_INIT_ALL_SCAN = 5'd9;
    localparam step_t STEP_ENABLE_DEV    = 5'd10;
    localparam step_t STEP_DISABLE_DEV   = 5'd11;
    localparam step_t STEP_DEV_ALL_ON    = 5'd12;
    localparam step_t STEP_DEV_ALL_OFF   = 5'd13;
    localparam step_t STEP_ENABLE_ALL    = 5'd14;
    localparam step_t STEP_DISABLE_ALL   = 5'd15;
    localparam step_t STEP_TEST_ON       = 5'd16;
    localparam step_t STEP_TEST_OFF      = 5'd17;

    typedef enum logic [1:0] {
        UOP_FETCH,
        UOP_STATUS,
        UOP_FRAME
    } uop_t;

    typedef enum logic [1:0] {
        ASRC_DIGIT_IN,
        ASRC_DIGIT_CNT,
        ASRC_CONST
    } addr_src_t;

    typedef enum logic [2:0] {
        DSRC_SEGMENT,
        DSRC_ZERO,
        DSRC_ONE,
        DSRC_ALL_ON,
        DSRC_DECODE,
        DSRC_INTENSITY,
        DSRC_SCAN_LIMIT
    } data_src_t;

    typedef enum logic {
        COND_NONE,
        COND_DIGIT_LOOP
    } cond_t;

    typedef struct packed {
        uop_t       uop;
        addr_src_t  asrc;
        logic [3:0] aconst;
        data_src_t  dsrc;
        logic       bcast;
        logic       last;
        cond_t      cond;
        step_t      next_step;
    } ucode_t;

    typedef struct packed {
        ucode_t uw;
        logic   load;
        logic   issue;
    } ctl_t;

    typedef struct packed {
        logic       slot_free;
        logic       frame_last;
        logic       digit_last;
        logic [2:0] status;
    } dp_stat_t;

endpackage

### hw/rtl/led_driver_chain_framer.sv
// ============================================================================
// led_driver_chain_framer
// Turns one command for a daisy chain of LED driver chips into chain words.
// ============================================================================
// One command is taken at a time. A rejected command gives its single status
// result through the status step and then the output register; otherwise
// the block emits F frames of N words, one word per cycle while the output
// is not stalled, farthest device first, where N is the effective chain
// length and F is 1, 3 (init) or 8 (device all on/off). A new command is
// taken only once the last word of the previous one has been issued to
// the output register. Command codes 12 to 15 are dropped with no result.
// Write configuration only while the block is idle.
module led_driver_chain_framer
    import ldcf_pkg::*;
#(
    parameter int MAX_CHAIN = MAX_CHAIN_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [3:0] command,
    input  logic [7:0] target_device,
    input  logic [7:0] digit_index,
    input  logic [7:0] segment_data,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] register_address,
    output logic [7:0] register_data,
    output logic       frame_end,
    output logic       command_end,
    output logic [2:0] status,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic [3:0] chain_length_reg;
    logic [7:0] decode_mode_reg;
    logic [3:0] intensity_reg;
    logic [2:0] scan_limit_reg;
    ctl_t       ctl;
    dp_stat_t   stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_length_reg <= 4'd1;
            decode_mode_reg  <= 8'd0;
            intensity_reg    <= 4'd0;
            scan_limit_reg   <= 3'd7;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CHAIN_LENGTH: chain_length_reg <= cfg_data[3:0];
                CFG_DECODE_MODE:  decode_mode_reg  <= cfg_data;
                CFG_INTENSITY:    intensity_reg    <= cfg_data[3:0];
                CFG_SCAN_LIMIT:   scan_limit_reg   <= cfg_data[2:0];
                default:          ;
            endcase
        end
    end

    ldcf_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .command  (command),
        .stat     (stat),
        .ctl      (ctl)
    );

    ldcf_datapath #(
        .MAX_CHAIN (MAX_CHAIN)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctl               (ctl),
        .stat              (stat),
        .command           (command),
        .target_device     (target_device),
        .digit_index       (digit_index),
        .segment_data      (segment_data),
        .chain_length      (chain_length_reg),
        .decode_mode_value (decode_mode_reg),
        .intensity_value   (intensity_reg),
        .scan_limit_value  (scan_limit_reg),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .register_address  (register_address),
        .register_data     (register_data),
        .frame_end         (frame_end),
        .command_end       (command_end),
        .status            (status)
    );

`ifndef SYNTH
    a_idle_after_command_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_stall |-> command_end)
        else $error("new command taken while a command is still being emitted");

    a_status_result_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |->
            command_end && !frame_end && (register_address == REG_NOOP))
        else $error("status result is not a lone no-op word");

    a_issue_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.issue |-> !out_valid || !out_stall)
        else $error("word issued over a stalled output register");
`endif

endmodule

### hw/rtl/ldcf_ucode_rom.sv
// ============================================================================
// ldcf_ucode_rom
// Microprogram store: one control word per sequencer step.
// ============================================================================
module ldcf_ucode_rom
    import ldcf_pkg::*;
(
    input  step_t  step,
    output ucode_t uword
);

    function automatic ucode_t frame_word(addr_src_t asrc, logic [3:0] aconst,
                                          data_src_t dsrc, logic bcast,
                                          logic last, cond_t cond,
                                          step_t next_step);
        ucode_t w;
        w.uop       = UOP_FRAME;
        w.asrc      = asrc;
        w.aconst    = aconst;
        w.dsrc      = dsrc;
        w.bcast     = bcast;
        w.last      = last;
        w.cond      = cond;
        w.next_step = next_step;
        return w;
    endfunction

    always_comb
    begin
        uword = '{uop: UOP_FETCH, asrc: ASRC_CONST, aconst: REG_NOOP, dsrc: DSRC_ZERO,
                  bcast: 1'b0, last: 1'b1, cond: COND_NONE, next_step: STEP_FETCH};
        case (step)
            STEP_STATUS:
                uword.uop = UOP_STATUS;
            STEP_WRITE_DIGIT:
                uword = frame_word(ASRC_DIGIT_IN, REG_NOOP, DSRC_SEGMENT, 1'b0, 1'b1,
                                   COND_NONE, STEP_FETCH);
            STEP_CLEAR_DIGIT:
                uword = frame_word(ASRC_DIGIT_IN, REG_NOOP, DSRC_ZERO, 1'b0, 1'b1,
                                   COND_NONE, STEP_FETCH);
            STEP_INIT_DEV:
                uword = frame_word(ASRC_CONST, REG_DECODE, DSRC_DECODE, 1'b0, 1'b0,
                                   COND_NONE, STEP_INIT_DEV_INT);
            STEP_INIT_DEV_INT:
                uword = frame_word(ASRC_CONST, REG_INTENSITY, DSRC_INTENSITY, 1'b0, 1'b0,
                                   COND_NONE, STEP_INIT_DEV_SCAN);
            STEP_INIT_DEV_SCAN:
                uword = frame_word(ASRC_CONST, REG_SCANLIM, DSRC_SCAN_LIMIT, 1'b0, 1'b1,
                                   COND_NONE, STEP_FETCH);
            STEP_INIT_ALL:
                uword = frame_word(ASRC_CONST, REG_DECODE, DSRC_DECODE, 1'b1, 1'b0,
                                   COND_NONE, STEP_INIT_ALL_INT);
            STEP_INIT_ALL_INT:
                uword = frame_word(ASRC_CONST, REG_INTENSITY, DSRC_INTENSITY, 1'b1, 1'b0,
                                   COND_NONE, STEP_INIT_ALL_SCAN);
            STEP_INIT_ALL_SCAN:
                uword = frame_word(ASRC_CONST, REG_SCANLIM, DSRC_SCAN_LIMIT, 1'b1, 1'b1,
                                   COND_NONE, STEP_FETCH);
            STEP_ENABLE_DEV:
                uword = frame_word(ASRC_CONST, REG_SHUTDOWN, DSRC_ONE, 1'b0, 1'b1,
                                   COND_NONE, STEP_FETCH);
            STEP_DISABLE_DEV:
                uword = frame_word(ASRC_CONST, REG_SHUTDOWN, DSRC_ZERO, 1'b0, 1'b1,
                                   COND_NONE, STEP_FETCH);
            STEP_DEV_ALL_ON:
                uword = frame_word(ASRC_DIGIT_CNT, REG_NOOP, DSRC_ALL_ON, 1'b0, 1'b1,
                                   COND_DIGIT_LOOP, STEP_DEV_ALL_ON);
            STEP_DEV_ALL_OFF:
                uword = frame_word(ASRC_DIGIT_CNT, REG_NOOP, DSRC_ZERO, 1'b0, 1'b1,
                                   COND_DIGIT_LOOP, STEP_DEV_ALL_OFF);
            STEP_ENABLE_ALL:
                uword = frame_word(ASRC_CONST, REG_SHUTDOWN, DSRC_ONE, 1'b1, 1'b1,
                                   COND_NONE, STEP_FETCH);
            STEP_DISABLE_ALL:
                uword = frame_word(ASRC_CONST, REG_SHUTDOWN, DSRC_ZERO, 1'b1, 1'b1,
                                   COND_NONE, STEP_FETCH);
            STEP_TEST_ON:
                uword = frame_word(ASRC_CONST, REG_TEST, DSRC_ONE, 1'b1, 1'b1,
                                   COND_NONE, STEP_FETCH);
            STEP_TEST_OFF:
                uword = frame_word(ASRC_CONST, REG_TEST, DSRC_ZERO, 1'b1, 1'b1,
                                   COND_NONE, STEP_FETCH);
            default:
                uword.uop = UOP_FETCH;
        endcase
    end

endmodule

### hw/rtl/ldcf_sequencer.sv
// ============================================================================
// ldcf_sequencer
// Step counter with command dispatch and conditional jumps over the microprogram.
// ============================================================================
module ldcf_sequencer
    import ldcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [3:0] command,
    input  dp_stat_t   stat,
    output ctl_t       ctl
);

    step_t  step_reg;
    step_t  step_next;
    ucode_t uw;
    logic   accept;

    function automatic step_t dispatch(logic [3:0] cmd);
        step_t s;
        case (cmd_t'(cmd))
            CMD_WRITE_DIGIT: s = STEP_WRITE_DIGIT;
            CMD_CLEAR_DIGIT: s = STEP_CLEAR_DIGIT;
            CMD_INIT_DEV:    s = STEP_INIT_DEV;
            CMD_ENABLE_DEV:  s = STEP_ENABLE_DEV;
            CMD_DISABLE_DEV: s = STEP_DISABLE_DEV;
            CMD_DEV_ALL_ON:  s = STEP_DEV_ALL_ON;
            CMD_DEV_ALL_OFF: s = STEP_DEV_ALL_OFF;
            CMD_INIT_ALL:    s = STEP_INIT_ALL;
            CMD_ENABLE_ALL:  s = STEP_ENABLE_ALL;
            CMD_DISABLE_ALL: s = STEP_DISABLE_ALL;
            CMD_TEST_ON:     s = STEP_TEST_ON;
            CMD_TEST_OFF:    s = STEP_TEST_OFF;
            default:         s = STEP_FETCH;
        endcase
        return s;
    endfunction

    ldcf_ucode_rom u_rom (
        .step  (step_reg),
        .uword (uw)
    );

    always_comb
    begin
        accept    = in_valid && (uw.uop == UOP_FETCH);
        in_stall  = (uw.uop != UOP_FETCH);
        ctl.uw    = uw;
        ctl.load  = accept;
        ctl.issue = ((uw.uop == UOP_STATUS) || (uw.uop == UOP_FRAME)) && stat.slot_free;
    end

    always_comb
    begin
        step_next = step_reg;
        case (uw.uop)
            UOP_FETCH:
            begin
                if (accept)
                begin
                    if (stat.status != ST_OK)
                        step_next = STEP_STATUS;
                    else
                        step_next = dispatch(command);
                end
            end
            UOP_STATUS:
            begin
                if (stat.slot_free)
                    step_next = STEP_FETCH;
            end
            UOP_FRAME:
            begin
                if (stat.slot_free && stat.frame_last)
                begin
                    if ((uw.cond == COND_DIGIT_LOOP) && !stat.digit_last)
                        step_next = uw.next_step;
                    else if (uw.last)
                        step_next = STEP_FETCH;
                    else
                        step_next = uw.next_step;
                end
            end
            default:
                step_next = STEP_FETCH;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_FETCH;
        else
            step_reg <= step_next;
    end

endmodule

### hw/rtl/ldcf_datapath.sv
// ============================================================================
// ldcf_datapath
// Command checks, device and digit counters, word select and output register.
// ============================================================================
module ldcf_datapath
    import ldcf_pkg::*;
#(
    parameter int MAX_CHAIN = MAX_CHAIN_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  ctl_t       ctl,
    output dp_stat_t   stat,
    input  logic [3:0] command,
    input  logic [7:0] target_device,
    input  logic [7:0] digit_index,
    input  logic [7:0] segment_data,
    input  logic [3:0] chain_length,
    input  logic [7:0] decode_mode_value,
    input  logic [3:0] intensity_value,
    input  logic [2:0] scan_limit_value,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] register_address,
    output logic [7:0] register_data,
    output logic       frame_end,
    output logic       command_end,
    output logic [2:0] status
);

    localparam int         CNT_W  = $clog2(MAX_CHAIN + 1);
    localparam logic [3:0] MAX_CL = 4'(MAX_CHAIN);

    logic [CNT_W-1:0] n_eff;
    logic [2:0]       chk_status;
    logic [7:0]       dev_reg;
    logic [3:0]       digit_reg;
    logic [7:0]       seg_reg;
    logic [2:0]       status_reg;
    logic [CNT_W-1:0] dev_cnt_reg;
    logic [CNT_W-1:0] dev_cnt_next;
    logic [3:0]       digit_cnt_reg;
    logic [3:0]       digit_cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [3:0]       addr_reg;
    logic [7:0]       data_reg;
    logic             fend_reg;
    logic             cend_reg;
    logic [2:0]       ostat_reg;
    logic             hit;
    logic             frame_last;
    logic             digit_last;
    logic             more_digits;
    logic [3:0]       sel_addr;
    logic [7:0]       sel_data;

    always_comb
    begin
        if (chain_length == 4'd0)
            n_eff = CNT_W'(1);
        else if (chain_length > MAX_CL)
            n_eff = CNT_W'(MAX_CHAIN);
        else
            n_eff = CNT_W'(chain_length);
    end

    always_comb
    begin
        chk_status = ST_OK;
        if (command inside {CMD_WRITE_DIGIT, CMD_CLEAR_DIGIT})
        begin
            if (digit_index > DIGIT_HI)
                chk_status = ST_DIGIT_HIGH;
            else if (digit_index < DIGIT_LO)
                chk_status = ST_DIGIT_LOW;
        end
        if ((chk_status == ST_OK) && (command <= CMD_DEV_ALL_OFF))
        begin
            if (target_device > 8'(n_eff))
                chk_status = ST_DEV_BEYOND;
            else if (target_device == 8'd0)
                chk_status = ST_DEV_ZERO;
        end
    end

    always_comb
    begin
        frame_last  = (dev_cnt_reg == CNT_W'(1));
        digit_last  = (digit_cnt_reg == DIGIT_HI[3:0]);
        more_digits = (ctl.uw.cond == COND_DIGIT_LOOP) && !digit_last;
        hit         = ctl.uw.bcast || (8'(dev_cnt_reg) == dev_reg);

        case (ctl.uw.asrc)
            ASRC_DIGIT_IN:  sel_addr = digit_reg;
            ASRC_DIGIT_CNT: sel_addr = digit_cnt_reg;
            ASRC_CONST:     sel_addr = ctl.uw.aconst;
            default:        sel_addr = REG_NOOP;
        endcase

        case (ctl.uw.dsrc)
            DSRC_SEGMENT:    sel_data = seg_reg;
            DSRC_ZERO:       sel_data = 8'd0;
            DSRC_ONE:        sel_data = 8'd1;
            DSRC_ALL_ON:     sel_data = ALL_ON_BYTE;
            DSRC_DECODE:     sel_data = decode_mode_value;
            DSRC_INTENSITY:  sel_data = 8'(intensity_value);
            DSRC_SCAN_LIMIT: sel_data = 8'(scan_limit_value);
            default:         sel_data = 8'd0;
        endcase

        stat.slot_free  = !out_valid_reg || !out_stall;
        stat.frame_last = frame_last;
        stat.digit_last = digit_last;
        stat.status     = chk_status;
    end

    always_comb
    begin
        dev_cnt_next   = dev_cnt_reg;
        digit_cnt_next = digit_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (ctl.load)
        begin
            dev_cnt_next   = n_eff;
            digit_cnt_next = DIGIT_LO[3:0];
        end
        else if (ctl.issue && (ctl.uw.uop == UOP_FRAME))
        begin
            if (frame_last)
            begin
                dev_cnt_next = n_eff;
                if (more_digits)
                    digit_cnt_next = digit_cnt_reg + 4'd1;
            end
            else
            begin
                dev_cnt_next = dev_cnt_reg - CNT_W'(1);
            end
        end
        if (ctl.issue)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_cnt_reg   <= CNT_W'(1);
            digit_cnt_reg <= DIGIT_LO[3:0];
            out_valid_reg <= 1'b0;
        end
        else
        begin
            dev_cnt_reg   <= dev_cnt_next;
            digit_cnt_reg <= digit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            dev_reg    <= target_device;
            digit_reg  <= digit_index[3:0];
            seg_reg    <= segment_data;
            status_reg <= chk_status;
        end
        if (ctl.issue)
        begin
            if (ctl.uw.uop == UOP_STATUS)
            begin
                addr_reg  <= REG_NOOP;
                data_reg  <= 8'd0;
                fend_reg  <= 1'b0;
                cend_reg  <= 1'b1;
                ostat_reg <= status_reg;
            end
            else
            begin
                addr_reg  <= hit ? sel_addr : REG_NOOP;
                data_reg  <= hit ? sel_data : 8'd0;
                fend_reg  <= frame_last;
                cend_reg  <= frame_last && ctl.uw.last && !more_digits;
                ostat_reg <= ST_OK;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign register_address = addr_reg;
    assign register_data    = data_reg;
    assign frame_end        = fend_reg;
    assign command_end      = cend_reg;
    assign status           = ostat_reg;

endmodule
